### hdl/hmb_pkg.sv
// ----------------------------------------------------------------------------
// Matching package
// Shared constants, register indexes and state types of the assignment solver.
// ----------------------------------------------------------------------------
`default_nettype none

package hmb_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int LABEL_BITS_DEF   = 40;
  localparam int WEIGHT_BITS      = 32;
  localparam int CFG_BITS         = 5;
  localparam int CFG_IDX_BITS     = 1;
  localparam int COL_BITS         = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLUMN_COUNT = 1'b1;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_CLEAR,
    CS_RM_RD,
    CS_RM_CMP,
    CS_AUG_INIT,
    CS_STEP,
    CS_SCAN_ADD,
    CS_SCAN_SUB,
    CS_CHECK,
    CS_UPD_ROW,
    CS_UPD_COL,
    CS_ADVANCE,
    CS_FLIP,
    CS_DONE
  } core_state_t;

  typedef enum logic [1:0] {
    TS_LOAD,
    TS_SOLVE,
    TS_EMIT
  } top_state_t;

endpackage

`default_nettype wire

### hdl/hmb_if.sv
// ----------------------------------------------------------------------------
// Matching channel interfaces
// Valid/ready channels for the weight input and the per-column results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hmb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hmb_pkg::WEIGHT_BITS-1:0] weight;
  modport source (output valid, output weight, input ready);
  modport sink (input valid, input weight, output ready);
endinterface

interface hmb_out_if;
  logic                            valid;
  logic                            ready;
  logic [hmb_pkg::COL_BITS-1:0]    column;
  logic [hmb_pkg::COL_BITS-1:0]    matched_row;
  logic                            matched;
  logic                            error;
  logic                            last;
  modport source (output valid, output column, output matched_row, output matched,
                  output error, output last, input ready);
  modport sink (input valid, input column, input matched_row, input matched,
                input error, input last, output ready);
endinterface

`default_nettype wire

### hdl/max_weight_bipartite_matching_top.sv
// ----------------------------------------------------------------------------
// Maximum-weight bipartite matching
// Gathers a weight matrix, solves the assignment and reports each column.
// ----------------------------------------------------------------------------
// Usage: write row_count and column_count (index 0 and 1) on the cfg port
// while idle; a write also restarts matrix gathering. Then send the matrix
// as signed Q16.16 weights in row-major order on the in channel, one per
// transaction. After the last weight the input stalls while the solver runs:
// it finds the row maxima, then for each row runs up to m+1 search steps,
// each a scan over the columns and a label update, all through one
// saturating adder. The out channel then carries one transaction per column,
// last set on the final column; with more rows than columns the solver is
// skipped and every column reports error. Results sit in an output register,
// so a stalled receiver only holds the emission of the next column.
// Reset (synchronous, active low) sets both counts to the maximum and empties
// the matrix gathering; the weight memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module max_weight_bipartite_matching_top #(
  parameter int MAX_VERTICES = hmb_pkg::MAX_VERTICES_DEF,
  parameter int LABEL_BITS   = hmb_pkg::LABEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  hmb_in_if.sink                              in_ch,
  hmb_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [hmb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [hmb_pkg::CFG_BITS-1:0]        cfg_wdata
);

  localparam int IW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);

  hmb_pkg::top_state_t state_r, state_nxt;
  logic [IW-1:0] n_r, n_nxt, m_r, m_nxt, c_r, c_nxt;
  logic [AW-1:0] load_r, load_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [hmb_pkg::COL_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic          matched_r, matched_nxt, err_r, err_nxt, last_r, last_nxt;

  logic          in_acc, load_last, bad_shape, start, done, emit_now;
  logic [IW-1:0] cfg_val, own, own_idx;

  hmb_core #(.MAX_VERTICES(MAX_VERTICES), .LABEL_BITS(LABEL_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en_i  (in_acc),
    .wr_addr_i(load_r),
    .wr_data_i(in_ch.weight),
    .n_i      (n_r),
    .m_i      (m_r),
    .start_i  (start),
    .done_o   (done),
    .own_idx_i(own_idx),
    .own_o    (own)
  );

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_val = IW'(1);
    end else if (int'(cfg_wdata) > MAX_VERTICES) begin
      cfg_val = IW'(MAX_VERTICES);
    end else begin
      cfg_val = IW'(cfg_wdata);
    end
  end

  assign in_ch.ready = (state_r == hmb_pkg::TS_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_last   = ((2*IW)'(load_r) + (2*IW)'(1)) == ((2*IW)'(n_r) * (2*IW)'(m_r));
  assign bad_shape   = n_r > m_r;
  assign start       = in_acc && load_last && !bad_shape;
  assign own_idx     = c_r + 1'b1;
  assign emit_now    = (state_r == hmb_pkg::TS_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    c_nxt         = c_r;
    load_nxt      = load_r;
    out_valid_nxt = out_valid_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    matched_nxt   = matched_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (cfg_we) begin
      load_nxt = '0;
      if (cfg_index == hmb_pkg::REG_ROW_COUNT) n_nxt = cfg_val;
      else m_nxt = cfg_val;
    end
    case (state_r)
      hmb_pkg::TS_LOAD: begin
        if (in_acc) begin
          if (load_last) begin
            load_nxt  = '0;
            c_nxt     = '0;
            state_nxt = bad_shape ? hmb_pkg::TS_EMIT : hmb_pkg::TS_SOLVE;
          end else begin
            load_nxt = load_r + 1'b1;
          end
        end
      end
      hmb_pkg::TS_SOLVE: begin
        if (done) state_nxt = hmb_pkg::TS_EMIT;
      end
      hmb_pkg::TS_EMIT: begin
        if (emit_now) begin
          out_valid_nxt = 1'b1;
          col_nxt       = hmb_pkg::COL_BITS'(c_r);
          err_nxt       = bad_shape;
          matched_nxt   = !bad_shape && (own != '0);
          row_nxt       = (!bad_shape && (own != '0)) ?
                          hmb_pkg::COL_BITS'(own - 1'b1) : '0;
          last_nxt      = (c_r == m_r - 1'b1);
          if (c_r == m_r - 1'b1) state_nxt = hmb_pkg::TS_LOAD;
          else c_nxt = c_r + 1'b1;
        end
      end
      default: begin
        state_nxt = hmb_pkg::TS_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hmb_pkg::TS_LOAD;
      n_r         <= IW'(MAX_VERTICES);
      m_r         <= IW'(MAX_VERTICES);
      load_r      <= '0;
      c_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      m_r         <= m_nxt;
      load_r      <= load_nxt;
      c_r         <= c_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    matched_r <= matched_nxt;
    err_r     <= err_nxt;
    last_r    <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.column      = col_r;
  assign out_ch.matched_row = row_r;
  assign out_ch.matched     = matched_r;
  assign out_ch.error       = err_r;
  assign out_ch.last        = last_r;

endmodule

`default_nettype wire

### hdl/hmb_alu.sv
// ----------------------------------------------------------------------------
// Saturating label adder
// Shared add/subtract unit that clamps to the signed label range.
// ----------------------------------------------------------------------------
`default_nettype none

module hmb_alu #(
  parameter int LABEL_BITS = hmb_pkg::LABEL_BITS_DEF
) (
  input  logic signed [LABEL_BITS-1:0] a_i,
  input  logic signed [LABEL_BITS-1:0] b_i,
  input  logic                         sub_i,
  output logic signed [LABEL_BITS-1:0] y_o
);

  logic signed [LABEL_BITS:0] a_ext;
  logic signed [LABEL_BITS:0] b_ext;
  logic signed [LABEL_BITS:0] sum;

  always_comb begin
    a_ext = {a_i[LABEL_BITS-1], a_i};
    b_ext = {b_i[LABEL_BITS-1], b_i};
    sum   = sub_i ? (a_ext - b_ext) : (a_ext + b_ext);
    if (sum[LABEL_BITS] != sum[LABEL_BITS-1]) begin
      y_o = sum[LABEL_BITS] ? {1'b1, {(LABEL_BITS-1){1'b0}}}
                            : {1'b0, {(LABEL_BITS-1){1'b1}}};
    end else begin
      y_o = sum[LABEL_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

### hdl/hmb_core.sv
// ----------------------------------------------------------------------------
// Assignment solver core
// Weight memory, label and slack storage and the sequencer that runs the
// labeling search one column per step through the shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

module hmb_core #(
  parameter int MAX_VERTICES = hmb_pkg::MAX_VERTICES_DEF,
  parameter int LABEL_BITS   = hmb_pkg::LABEL_BITS_DEF,
  localparam int IW          = $clog2(MAX_VERTICES + 1),
  localparam int AW          = $clog2(MAX_VERTICES * MAX_VERTICES)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en_i,
  input  logic [AW-1:0]                   wr_addr_i,
  input  logic [hmb_pkg::WEIGHT_BITS-1:0] wr_data_i,
  input  logic [IW-1:0]                   n_i,
  input  logic [IW-1:0]                   m_i,
  input  logic                            start_i,
  output logic                            done_o,
  input  logic [IW-1:0]                   own_idx_i,
  output logic [IW-1:0]                   own_o
);

  localparam logic signed [LABEL_BITS-1:0] LAB_MAX = {1'b0, {(LABEL_BITS-1){1'b1}}};
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;

  logic [hmb_pkg::WEIGHT_BITS-1:0] mem [0:DEPTH-1];
  logic signed [hmb_pkg::WEIGHT_BITS-1:0] w_rd_r;

  logic signed [LABEL_BITS-1:0] rl_r    [0:MAX_VERTICES];
  logic signed [LABEL_BITS-1:0] cl_r    [0:MAX_VERTICES];
  logic signed [LABEL_BITS-1:0] slack_r [0:MAX_VERTICES];
  logic [IW-1:0]                own_r   [0:MAX_VERTICES];
  logic [IW-1:0]                pred_r  [0:MAX_VERTICES];
  logic                         vis_r   [0:MAX_VERTICES];

  hmb_pkg::core_state_t state_r, state_nxt;
  logic [IW-1:0] s_r, s_nxt;
  logic [IW-1:0] u_r, u_nxt;
  logic [IW-1:0] v_r, v_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] nx_r, nx_nxt;
  logic [IW-1:0] step_r, step_nxt;
  logic signed [LABEL_BITS-1:0] minh_r, minh_nxt;
  logic signed [LABEL_BITS-1:0] t_r, t_nxt;
  logic signed [LABEL_BITS-1:0] mx_r, mx_nxt;

  logic signed [LABEL_BITS-1:0] alu_a, alu_b, alu_y;
  logic                         alu_sub;
  logic signed [LABEL_BITS-1:0] w_ext, mx_cand, slack_i, new_sl;
  logic                         d_lt, min_upd, i_last, row_end;
  logic [IW-1:0]                rl_idx, row_sel, row_m1, col_m1;
  logic [2*IW-1:0]              addr_full;
  logic [AW-1:0]                rd_addr;

  hmb_alu #(.LABEL_BITS(LABEL_BITS)) u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sub_i(alu_sub),
    .y_o  (alu_y)
  );

  always_comb begin
    row_sel   = (state_r == hmb_pkg::CS_RM_RD) ? s_r : v_r;
    row_m1    = row_sel - 1'b1;
    col_m1    = i_r - 1'b1;
    addr_full = (2*IW)'(row_m1) * (2*IW)'(m_i) + (2*IW)'(col_m1);
    rd_addr   = addr_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    w_rd_r <= mem[rd_addr];
  end

  always_comb begin
    w_ext   = LABEL_BITS'(w_rd_r);
    mx_cand = (w_ext > mx_r) ? w_ext : mx_r;
    i_last  = (i_r == m_i);
    rl_idx  = (state_r == hmb_pkg::CS_SCAN_ADD) ? v_r : own_r[i_r];
    slack_i = slack_r[i_r];
    alu_a   = rl_r[rl_idx];
    alu_b   = cl_r[i_r];
    alu_sub = 1'b0;
    case (state_r)
      hmb_pkg::CS_SCAN_SUB: begin
        alu_a   = t_r;
        alu_b   = w_ext;
        alu_sub = 1'b1;
      end
      hmb_pkg::CS_UPD_ROW: begin
        alu_a   = vis_r[i_r] ? rl_r[rl_idx] : slack_i;
        alu_b   = minh_r;
        alu_sub = 1'b1;
      end
      hmb_pkg::CS_UPD_COL: begin
        alu_a = cl_r[i_r];
        alu_b = minh_r;
      end
      default: begin
      end
    endcase
    d_lt    = alu_y < slack_i;
    new_sl  = d_lt ? alu_y : slack_i;
    min_upd = minh_r > new_sl;
  end

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    i_nxt     = i_r;
    nx_nxt    = nx_r;
    step_nxt  = step_r;
    minh_nxt  = minh_r;
    t_nxt     = t_r;
    mx_nxt    = mx_r;
    row_end   = 1'b0;
    case (state_r)
      hmb_pkg::CS_IDLE: begin
        if (start_i) state_nxt = hmb_pkg::CS_CLEAR;
      end
      hmb_pkg::CS_CLEAR: begin
        s_nxt     = IW'(1);
        i_nxt     = IW'(1);
        mx_nxt    = '0;
        state_nxt = hmb_pkg::CS_RM_RD;
      end
      hmb_pkg::CS_RM_RD: begin
        state_nxt = hmb_pkg::CS_RM_CMP;
      end
      hmb_pkg::CS_RM_CMP: begin
        if (i_last) begin
          mx_nxt = '0;
          i_nxt  = IW'(1);
          if (s_r == n_i) begin
            s_nxt     = IW'(1);
            state_nxt = hmb_pkg::CS_AUG_INIT;
          end else begin
            s_nxt     = s_r + 1'b1;
            state_nxt = hmb_pkg::CS_RM_RD;
          end
        end else begin
          mx_nxt    = mx_cand;
          i_nxt     = i_r + 1'b1;
          state_nxt = hmb_pkg::CS_RM_RD;
        end
      end
      hmb_pkg::CS_AUG_INIT: begin
        u_nxt     = '0;
        step_nxt  = '0;
        state_nxt = hmb_pkg::CS_STEP;
      end
      hmb_pkg::CS_STEP: begin
        v_nxt     = own_r[u_r];
        minh_nxt  = LAB_MAX;
        nx_nxt    = '0;
        i_nxt     = IW'(1);
        state_nxt = hmb_pkg::CS_SCAN_ADD;
      end
      hmb_pkg::CS_SCAN_ADD: begin
        if (vis_r[i_r]) begin
          if (i_last) state_nxt = hmb_pkg::CS_CHECK;
          else i_nxt = i_r + 1'b1;
        end else begin
          t_nxt     = alu_y;
          state_nxt = hmb_pkg::CS_SCAN_SUB;
        end
      end
      hmb_pkg::CS_SCAN_SUB: begin
        if (min_upd) begin
          minh_nxt = new_sl;
          nx_nxt   = i_r;
        end
        if (i_last) begin
          state_nxt = hmb_pkg::CS_CHECK;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = hmb_pkg::CS_SCAN_ADD;
        end
      end
      hmb_pkg::CS_CHECK: begin
        if (nx_r == '0) begin
          row_end = 1'b1;
        end else begin
          i_nxt     = '0;
          state_nxt = hmb_pkg::CS_UPD_ROW;
        end
      end
      hmb_pkg::CS_UPD_ROW: begin
        if (vis_r[i_r]) begin
          state_nxt = hmb_pkg::CS_UPD_COL;
        end else if (i_last) begin
          state_nxt = hmb_pkg::CS_ADVANCE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      hmb_pkg::CS_UPD_COL: begin
        if (i_last) begin
          state_nxt = hmb_pkg::CS_ADVANCE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = hmb_pkg::CS_UPD_ROW;
        end
      end
      hmb_pkg::CS_ADVANCE: begin
        u_nxt = nx_r;
        if (own_r[nx_r] == '0) begin
          step_nxt  = '0;
          state_nxt = hmb_pkg::CS_FLIP;
        end else if (step_r == m_i) begin
          row_end = 1'b1;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = hmb_pkg::CS_STEP;
        end
      end
      hmb_pkg::CS_FLIP: begin
        if (u_r == '0) begin
          row_end = 1'b1;
        end else begin
          u_nxt = pred_r[u_r];
          if (step_r == m_i) row_end = 1'b1;
          else step_nxt = step_r + 1'b1;
        end
      end
      hmb_pkg::CS_DONE: begin
        state_nxt = hmb_pkg::CS_IDLE;
      end
      default: begin
        state_nxt = hmb_pkg::CS_IDLE;
      end
    endcase
    if (row_end) begin
      if (s_r == n_i) begin
        state_nxt = hmb_pkg::CS_DONE;
      end else begin
        s_nxt     = s_r + 1'b1;
        state_nxt = hmb_pkg::CS_AUG_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hmb_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    s_r    <= s_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    i_r    <= i_nxt;
    nx_r   <= nx_nxt;
    step_r <= step_nxt;
    minh_r <= minh_nxt;
    t_r    <= t_nxt;
    mx_r   <= mx_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      hmb_pkg::CS_CLEAR: begin
        for (int k = 0; k <= MAX_VERTICES; k++) begin
          rl_r[k]    <= '0;
          cl_r[k]    <= '0;
          slack_r[k] <= LAB_MAX;
          own_r[k]   <= '0;
          pred_r[k]  <= '0;
          vis_r[k]   <= 1'b0;
        end
      end
      hmb_pkg::CS_RM_CMP: begin
        if (i_last) rl_r[s_r] <= mx_cand;
      end
      hmb_pkg::CS_AUG_INIT: begin
        for (int k = 1; k <= MAX_VERTICES; k++) begin
          if (k <= int'(m_i)) begin
            vis_r[k]   <= 1'b0;
            pred_r[k]  <= '0;
            slack_r[k] <= LAB_MAX;
          end
        end
        own_r[0] <= s_r;
      end
      hmb_pkg::CS_STEP: begin
        vis_r[u_r] <= 1'b1;
      end
      hmb_pkg::CS_SCAN_SUB: begin
        if (d_lt) begin
          slack_r[i_r] <= alu_y;
          pred_r[i_r]  <= u_r;
        end
      end
      hmb_pkg::CS_UPD_ROW: begin
        if (vis_r[i_r]) rl_r[rl_idx] <= alu_y;
        else slack_r[i_r] <= alu_y;
      end
      hmb_pkg::CS_UPD_COL: begin
        cl_r[i_r] <= alu_y;
      end
      hmb_pkg::CS_FLIP: begin
        if (u_r != '0) own_r[u_r] <= own_r[pred_r[u_r]];
      end
      default: begin
      end
    endcase
  end

  assign done_o = (state_r == hmb_pkg::CS_DONE);
  assign own_o  = own_r[own_idx_i];

`ifndef SYNTHESIS
  a_sub_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hmb_pkg::CS_SCAN_SUB |-> $past(state_r) == hmb_pkg::CS_SCAN_ADD)
    else $error("Slack subtraction without a preceding label sum.");
  a_col_after_row: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hmb_pkg::CS_UPD_COL |-> $past(state_r) == hmb_pkg::CS_UPD_ROW)
    else $error("Column label update without a row label update.");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> state_r == hmb_pkg::CS_IDLE)
    else $error("Solver started while busy.");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_o |=> state_r == hmb_pkg::CS_IDLE)
    else $error("Solver did not return to idle after completion.");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// Assignment solver testbench
// Loads weight matrices of many shapes into the matching block, predicts the
// optimal row for every column with a behavioral Hungarian solver and checks
// each result transaction in order, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int     NV        = hmb_pkg::MAX_VERTICES_DEF + 1;
  localparam longint LABEL_MAX = (64'sd1 <<< (hmb_pkg::LABEL_BITS_DEF - 1)) - 1;
  localparam longint LABEL_MIN = -LABEL_MAX - 1;
  localparam int     SETTLE    = 40;

  typedef struct packed {
    logic [hmb_pkg::COL_BITS-1:0] column;
    logic [hmb_pkg::COL_BITS-1:0] matched_row;
    logic                         matched;
    logic                         error;
    logic                         last;
  } column_result_t;

  logic clk;
  logic rst_n;
  logic                             cfg_we;
  logic [hmb_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [hmb_pkg::CFG_BITS-1:0]     cfg_wdata;

  hmb_in_if  in_ch ();
  hmb_out_if out_ch ();

  max_weight_bipartite_matching_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Solver state of the predictor.
  longint weights[hmb_pkg::MAX_VERTICES_DEF * hmb_pkg::MAX_VERTICES_DEF];
  longint row_lab[NV];
  longint col_lab[NV];
  longint slack[NV];
  int     owner[NV];
  int     prev_col[NV];
  bit     seen[NV];
  int     loaded;
  int     rows;
  int     cols;

  column_result_t expected_columns[$];
  int  mismatches;
  bit  stalls_on;
  int  ready_hold;

  function automatic longint lab_add(longint a, longint b);
    if (b > 0 && a > LABEL_MAX - b) return LABEL_MAX;
    if (b < 0 && a < LABEL_MIN - b) return LABEL_MIN;
    return a + b;
  endfunction

  function automatic longint lab_sub(longint a, longint b);
    if (b < 0 && a > LABEL_MAX + b) return LABEL_MAX;
    if (b > 0 && a < LABEL_MIN + b) return LABEL_MIN;
    return a - b;
  endfunction

  function automatic int clamp_count(logic [hmb_pkg::CFG_BITS-1:0] v);
    int c;
    c = v;
    if (c < 1) c = 1;
    if (c > hmb_pkg::MAX_VERTICES_DEF) c = hmb_pkg::MAX_VERTICES_DEF;
    return c;
  endfunction

  function automatic void grow_path(int s);
    int u;
    int v;
    int nxt;
    int p;
    longint d;
    longint minh;
    u = 0;
    for (int i = 1; i <= cols; i++) begin
      seen[i] = 1'b0;
      prev_col[i] = 0;
      slack[i] = LABEL_MAX;
    end
    owner[0] = s;
    for (int st = 0; st <= cols; st++) begin
      v = owner[u];
      nxt = 0;
      minh = LABEL_MAX;
      seen[u] = 1'b1;
      for (int i = 1; i <= cols; i++) begin
        if (!seen[i]) begin
          d = lab_sub(lab_add(row_lab[v], col_lab[i]), weights[(v - 1) * cols + i - 1]);
          if (d < slack[i]) begin
            slack[i] = d;
            prev_col[i] = u;
          end
          if (minh > slack[i]) begin
            minh = slack[i];
            nxt = i;
          end
        end
      end
      if (nxt == 0) return;
      for (int i = 0; i <= cols; i++) begin
        if (seen[i]) begin
          row_lab[owner[i]] = lab_sub(row_lab[owner[i]], minh);
          col_lab[i] = lab_add(col_lab[i], minh);
        end else begin
          slack[i] = lab_sub(slack[i], minh);
        end
      end
      u = nxt;
      if (owner[u] == 0) break;
    end
    if (owner[u] != 0) return;
    for (int st = 0; st <= cols && u != 0; st++) begin
      p = prev_col[u];
      owner[u] = owner[p];
      u = p;
    end
  endfunction

  function automatic void solve_matrix();
    longint mx;
    for (int i = 0; i < NV; i++) begin
      row_lab[i] = 0;
      col_lab[i] = 0;
      owner[i] = 0;
      prev_col[i] = 0;
      seen[i] = 1'b0;
      slack[i] = LABEL_MAX;
    end
    for (int i = 1; i <= rows; i++) begin
      mx = 0;
      for (int j = 1; j <= cols; j++)
        if (weights[(i - 1) * cols + j - 1] > mx) mx = weights[(i - 1) * cols + j - 1];
      row_lab[i] = mx;
    end
    for (int i = 1; i <= rows; i++) grow_path(i);
  endfunction

  function automatic void absorb_weight(logic signed [hmb_pkg::WEIGHT_BITS-1:0] w);
    column_result_t r;
    bit err;
    if (loaded >= rows * cols) loaded = 0;
    weights[loaded] = longint'(w);
    loaded++;
    if (loaded < rows * cols) return;
    loaded = 0;
    err = rows > cols;
    if (!err) solve_matrix();
    for (int c = 0; c < cols; c++) begin
      r.column = c[hmb_pkg::COL_BITS-1:0];
      r.matched = !err && owner[c + 1] != 0;
      r.matched_row = r.matched ? hmb_pkg::COL_BITS'(owner[c + 1] - 1) : '0;
      r.error = err;
      r.last = (c + 1 == cols);
      expected_columns.push_back(r);
    end
  endfunction

  task automatic send_weight(logic signed [hmb_pkg::WEIGHT_BITS-1:0] w);
    if (stalls_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.weight <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_weight(w);
  endtask

  task automatic write_count(logic [hmb_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [hmb_pkg::CFG_BITS-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_columns.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hmb_pkg::REG_ROW_COUNT) rows = clamp_count(value);
    else cols = clamp_count(value);
    loaded = 0;
  endtask

  task automatic set_shape(int r, int c);
    write_count(hmb_pkg::REG_ROW_COUNT, hmb_pkg::CFG_BITS'(r));
    write_count(hmb_pkg::REG_COLUMN_COUNT, hmb_pkg::CFG_BITS'(c));
  endtask

  function automatic logic signed [hmb_pkg::WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return hmb_pkg::WEIGHT_BITS'($signed($urandom_range(0, 8)) - 4) <<< 16;
      2: return $signed(hmb_pkg::WEIGHT_BITS'($urandom_range(0, 200000))) - 100000;
      default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  task automatic test_single_cell();
    set_shape(1, 1);
    send_weight(32'sh7fffffff);
    send_weight(32'sh80000000);
  endtask

  task automatic test_clamped_counts();
    write_count(hmb_pkg::REG_ROW_COUNT, 5'd0);
    write_count(hmb_pkg::REG_COLUMN_COUNT, 5'd3);
    send_weight(32'sh80000000);
    send_weight(32'sh00000000);
    send_weight(-32'sh00010000);
  endtask

  task automatic test_more_rows_than_columns();
    set_shape(3, 2);
    for (int i = 0; i < 6; i++) send_weight(pick_weight());
  endtask

  task automatic test_unmatched_columns();
    set_shape(2, 3);
    send_weight(32'sh00050000);
    send_weight(32'sh00030000);
    send_weight(-32'sh00020000);
    send_weight(32'sh00050000);
    send_weight(32'sh00010000);
    send_weight(32'sh7fffffff);
  endtask

  task automatic test_restart_on_write();
    set_shape(2, 2);
    for (int i = 0; i < 3; i++) send_weight(pick_weight());
    write_count(hmb_pkg::REG_COLUMN_COUNT, 5'd2);
    for (int i = 0; i < 4; i++) send_weight(pick_weight());
  endtask

  task automatic test_clamped_width();
    write_count(hmb_pkg::REG_ROW_COUNT, 5'd2);
    write_count(hmb_pkg::REG_COLUMN_COUNT, 5'd31);
    for (int i = 0; i < rows * cols; i++) send_weight(pick_weight());
  endtask

  task automatic test_random_matrices();
    int sent;
    sent = 0;
    while (sent < 75) begin
      if (sent > 55) stalls_on = 1'b0;
      if ($urandom_range(0, 9) == 0) set_shape($urandom_range(1, 16), $urandom_range(1, 2));
      else set_shape($urandom_range(1, 4), $urandom_range(1, 5));
      for (int i = 0; i < rows * cols; i++) send_weight(pick_weight());
      sent += rows * cols;
    end
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (rst_n && stalls_on && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 11);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    column_result_t want;
    column_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.column, out_ch.matched_row, out_ch.matched, out_ch.error, out_ch.last};
      if (expected_columns.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
      end else begin
        want = expected_columns.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    mismatches = 0;
    stalls_on = 1'b1;
    rows = hmb_pkg::MAX_VERTICES_DEF;
    cols = hmb_pkg::MAX_VERTICES_DEF;
    loaded = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= hmb_pkg::REG_ROW_COUNT;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.weight <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_cell();
    test_clamped_counts();
    test_more_rows_than_columns();
    test_unmatched_columns();
    test_restart_on_write();
    test_clamped_width();
    test_random_matrices();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_columns.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/hmb_pkg.sv
hdl/hmb_if.sv
hdl/hmb_alu.sv
hdl/hmb_core.sv
hdl/max_weight_bipartite_matching_top.sv
sim/tb.sv
